@@ rtl/csle_pkg.sv @@
// Shared types, constants and character helpers for the string literal escaper.
`timescale 1ns / 1ps

package csle_pkg;

	typedef struct packed {
		logic       opcode;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
	} out_item_t;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_CHR  = 2'd2
	} run_mode_t;

	// Character slots of one transaction's output, in emission order.
	localparam int POS_Q1      = 0;
	localparam int POS_SEP0    = 1;
	localparam int POS_SEP1    = 2;
	localparam int POS_SEP2    = 3;
	localparam int POS_Q2      = 4;
	localparam int POS_BSL     = 5;
	localparam int POS_BODY    = 6;
	localparam int TXT_LEN     = 14;
	localparam int POS_TXT0    = 7;
	localparam int POS_TXT_END = POS_TXT0 + TXT_LEN - 1;
	localparam int POS_DH      = POS_TXT_END + 1;
	localparam int POS_DT      = POS_DH + 1;
	localparam int POS_DO      = POS_DT + 1;
	localparam int POS_RPAR    = POS_DO + 1;
	localparam int NPOS        = POS_RPAR + 1;
	localparam int POS_W       = $clog2(NPOS);

	localparam logic [8*TXT_LEN-1:0] CHR_TXT = "char(0, 0, 0, ";

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// One queued transaction: which slots to emit plus the variable characters.
	typedef struct packed {
		logic [NPOS-1:0] mask;
		logic [7:0]      body_char;
		logic [3:0]      dig_h;
		logic [3:0]      dig_t;
		logic [3:0]      dig_o;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [POS_W-1:0] first_pos(input logic [NPOS-1:0] mask);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = NPOS - 1; i >= 0; i--) begin
			if (mask[i]) p = i[POS_W-1:0];
		end
		return p;
	endfunction

	function automatic logic [7:0] char_at(input logic [POS_W-1:0] pos, input qent_t ent);
		logic [7:0] c;
		int         k;
		k = int'(pos) - POS_TXT0;
		c = CH_QUOTE;
		case (int'(pos)) inside
			POS_Q1, POS_Q2:         c = CH_QUOTE;
			POS_SEP0, POS_SEP2:     c = CH_SPACE;
			POS_SEP1:               c = CH_AMP;
			POS_BSL:                c = CH_BSL;
			POS_BODY:               c = ent.body_char;
			[POS_TXT0:POS_TXT_END]: c = CHR_TXT[8*(TXT_LEN-1-k) +: 8];
			POS_DH:                 c = CH_ZERO | {4'd0, ent.dig_h};
			POS_DT:                 c = CH_ZERO | {4'd0, ent.dig_t};
			POS_DO:                 c = CH_ZERO | {4'd0, ent.dig_o};
			POS_RPAR:               c = CH_RPAR;
			default:                c = CH_QUOTE;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/csle_front.sv @@
// Front end: accepts input transactions, tracks the run mode and builds slot plans.
`timescale 1ns / 1ps

module csle_front import csle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  q_stat_t  q_stat,
	output logic     push,
	output qent_t    push_ent
);

	run_mode_t mode_q, mode_d;
	logic      accept;
	logic      printable;
	logic      escaped;
	logic      is_ctrl;
	logic [7:0] b;
	logic [1:0] hund;
	logic [7:0] rem;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [7:0]  tens_x10;

	assign b         = in_item.char_byte;
	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign is_ctrl   = (b >= 8'h07) && (b <= 8'h0D);
	assign printable = ((b >= 8'h20) && (b <= 8'h7E)) || is_ctrl;
	assign escaped   = is_ctrl || (b == CH_BSL) || (b == CH_QUOTE);

	// Decimal digits: tens via multiply by reciprocal of ten, exact below 1029.
	assign hund      = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
	assign rem       = b - ({6'd0, hund} * 8'd100);
	assign tens_prod = 15'(rem[6:0]) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign tens_x10  = {tens, 3'b000} + {3'b000, tens, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		mode_d             = mode_q;
		push_ent.mask      = '0;
		push_ent.body_char = b;
		push_ent.dig_h     = {2'b00, hund};
		push_ent.dig_t     = tens;
		push_ent.dig_o     = 4'(rem - tens_x10);
		if (is_ctrl) begin
			case (b)
				8'h07:   push_ent.body_char = "a";
				8'h08:   push_ent.body_char = "b";
				8'h09:   push_ent.body_char = "t";
				8'h0A:   push_ent.body_char = "n";
				8'h0B:   push_ent.body_char = "v";
				8'h0C:   push_ent.body_char = "f";
				default: push_ent.body_char = "r";
			endcase
		end
		if (in_item.opcode == OP_FLUSH) begin
			case (mode_q)
				MODE_RUN: push_ent.mask[POS_Q1] = 1'b1;
				MODE_CHR: ;
				default: begin
					push_ent.mask[POS_Q1] = 1'b1;
					push_ent.mask[POS_Q2] = 1'b1;
				end
			endcase
			mode_d = MODE_IDLE;
		end else if (printable) begin
			if (mode_q == MODE_CHR) push_ent.mask[POS_SEP0 +: 3] = '1;
			if (mode_q != MODE_RUN) push_ent.mask[POS_Q2] = 1'b1;
			push_ent.mask[POS_BSL]  = escaped;
			push_ent.mask[POS_BODY] = 1'b1;
			mode_d = MODE_RUN;
		end else begin
			if (mode_q == MODE_RUN) push_ent.mask[POS_Q1] = 1'b1;
			if (mode_q == MODE_RUN || mode_q == MODE_CHR) push_ent.mask[POS_SEP0 +: 3] = '1;
			push_ent.mask[POS_TXT0 +: TXT_LEN] = '1;
			push_ent.mask[POS_DH]   = (b >= 8'd100);
			push_ent.mask[POS_DT]   = (b >= 8'd10);
			push_ent.mask[POS_DO]   = 1'b1;
			push_ent.mask[POS_RPAR] = 1'b1;
			mode_d = MODE_CHR;
		end
	end

	// Drop transactions that produce no characters.
	assign push = accept && (push_ent.mask != '0);

endmodule

@@ rtl/csle_queue.sv @@
// Small register queue of slot plans between front and back end.
`timescale 1ns / 1ps

module csle_queue import csle_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qent_t   push_ent,
	input  logic    pop,
	output qent_t   head,
	output q_stat_t q_stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qent_t          mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign head         = mem[rd_ptr_q];
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/csle_back.sv @@
// Back end: emits the head plan's slots, one per cycle unless stalled.
`timescale 1ns / 1ps

module csle_back import csle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qent_t     head,
	input  q_stat_t   q_stat,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [NPOS-1:0]  mask_q;
	logic             started_q;
	logic [NPOS-1:0]  eff_mask;
	logic [NPOS-1:0]  rest;
	logic [POS_W-1:0] pos;
	logic             last;
	logic             emit;
	logic             out_valid_q;
	out_item_t        out_item_q;

	assign eff_mask = started_q ? mask_q : head.mask;
	assign pos      = first_pos(eff_mask);
	assign rest     = eff_mask & (eff_mask - {{(NPOS-1){1'b0}}, 1'b1});
	assign last     = (rest == '0);
	assign emit     = !q_stat.empty && (!out_valid_q || out_ready);
	assign pop      = emit && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				started_q   <= !last;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance through the remaining slots; payload needs no reset.
	always_ff @(posedge clk) begin
		if (emit) begin
			mask_q              <= rest;
			out_item_q.out_char <= char_at(pos, head);
			out_item_q.run_last <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ rtl/charstring_literal_escaper_unit.sv @@
// Top level of the string literal escaper: front end, plan queue and back end.
`timescale 1ns / 1ps

// Feed a byte string one byte per transaction (opcode 0) and close it with a flush
// (opcode 1); the unit returns the quoted literal text one character per output
// transaction, with run_last set on the final character caused by each input. The
// front end takes one input per cycle while the plan queue (QUEUE_DEPTH entries)
// has room; the back end emits one character per cycle while a plan is queued and
// the output is not stalled; each input yields 1 to 6 characters for printable bytes,
// 16 to 22 for other bytes and 0 to 2 for a flush. Output characters are limited by
// the single character port of the back end. No clearing pass is needed after reset.

module charstring_literal_escaper_unit import csle_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	qent_t   push_ent;
	qent_t   head;

	csle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_stat   (q_stat),
		.push     (push),
		.push_ent (push_ent)
	);

	csle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	csle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("plan pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("plan popped from empty queue");

	a_plan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_ent.mask != '0))
		else $error("queued plan has no characters");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && out_item.run_last))
		else $error("finished plan did not end with run_last");

endmodule
